[src/frf_pkg.sv]
`timescale 1ns / 1ps
package frf_pkg;

  localparam int DEF_MAX_FAULTS = 1024;
  localparam int DEF_MAX_GROUPS = 4096;
  localparam int DEF_SIG_BITS   = 32;
  localparam int DEF_DICT_DEPTH = 1024;

  localparam int FID_W   = 10;
  localparam int SIG_W   = 32;
  localparam int GID_W   = 12;
  localparam int SZ_W    = 11;
  localparam int EPOCH_W = 8;
  localparam int QDEPTH  = 2;

  localparam logic [SZ_W-1:0] SZ_SAT = 11'd2047;

  typedef enum logic [1:0] {
    REQ_BEGIN  = 2'd0,
    REQ_REPORT = 2'd1,
    REQ_VEND   = 2'd2,
    REQ_QUERY  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_GROUPS_OUT = 2'd1,
    ST_DICT_FULL  = 2'd2,
    ST_BAD_ID     = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_FAULT_COUNT = 1'b0,
    CFG_DROP        = 1'b1
  } cfg_e;

  typedef enum logic [2:0] {
    K_BEGIN  = 3'd0,
    K_REPORT = 3'd1,
    K_VEND   = 3'd2,
    K_QUERY  = 3'd3,
    K_BAD    = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [FID_W-1:0]  fid;
    logic [SIG_W-1:0]  key;
    logic [SZ_W-1:0]   live;
  } item_t;

endpackage

[src/fault_signature_partition_refiner.sv]
`timescale 1ns / 1ps
// Channel  | handshake                | payload
// ---------+--------------------------+-------------------------------------------
// in       | in_valid_i / in_ready_o  | req_type_i, fault_id_i, signature_i
// out      | out_valid_o / out_ready_i| status_o, group_id_o, group_members_o,
//          |                          | skip_fault_o
// cfg      | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// Reports probe the dictionary linearly from a folded hash; the single
// read/write ports of the map, size and dictionary memories serialise the steps.
// Reset and every begin start a sweep over max(MAX_FAULTS, DICT_DEPTH) addresses
// (1024 by default) that zeroes the fault map and dictionary tags; every 255th
// vector end sweeps the tags alone. Items queue (two deep) during a sweep.
// A stalled output holds its item in the output register; the back end waits.
module fault_signature_partition_refiner import frf_pkg::*; #(
  parameter int MAX_FAULTS = DEF_MAX_FAULTS,
  parameter int MAX_GROUPS = DEF_MAX_GROUPS,
  parameter int SIG_BITS   = DEF_SIG_BITS,
  parameter int DICT_DEPTH = DEF_DICT_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       req_type_i,
  input  logic [FID_W-1:0] fault_id_i,
  input  logic [SIG_W-1:0] signature_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [GID_W-1:0] group_id_o,
  output logic [SZ_W-1:0]  group_members_o,
  output logic             skip_fault_o,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [SZ_W-1:0]  cfg_wdata_i
);

  logic [SZ_W-1:0] fault_count_q;
  logic            drop_singletons_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_count_q     <= '0;
      drop_singletons_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_FAULT_COUNT: fault_count_q     <= cfg_wdata_i;
        CFG_DROP:        drop_singletons_q <= cfg_wdata_i[0];
        default:         fault_count_q     <= fault_count_q;
      endcase
    end
  end

  logic  q_full, q_valid, q_push, q_pop;
  item_t q_in, q_head;

  // front: classify the item and check the fault id
  frf_front #(
    .MAX_FAULTS(MAX_FAULTS),
    .SIG_BITS  (SIG_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .req_type_i   (req_type_i),
    .fault_id_i   (fault_id_i),
    .signature_i  (signature_i),
    .fault_count_i(fault_count_q),
    .q_full_i     (q_full),
    .in_ready_o   (in_ready_o),
    .push_o       (q_push),
    .item_o       (q_in)
  );

  // short queue decouples front and back
  frf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .full_o (q_full),
    .head_o (q_head)
  );

  // back: dictionary probe, group moves and sweeps
  frf_back #(
    .MAX_FAULTS(MAX_FAULTS),
    .MAX_GROUPS(MAX_GROUPS),
    .SIG_BITS  (SIG_BITS),
    .DICT_DEPTH(DICT_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .drop_i         (drop_singletons_q),
    .q_valid_i      (q_valid),
    .q_item_i       (q_head),
    .q_pop_o        (q_pop),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .group_id_o     (group_id_o),
    .group_members_o(group_members_o),
    .skip_fault_o   (skip_fault_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid) else $error("queue full but empty");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_BAD_ID)) |->
      (group_id_o == '0 && group_members_o == '0 && !skip_fault_o))
    else $error("bad id result carries data");

  a_skip_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && skip_fault_o) |-> (drop_singletons_q && group_members_o <= SZ_W'(1)))
    else $error("skip flag without singleton");
`endif

endmodule

[src/frf_front.sv]
`timescale 1ns / 1ps
module frf_front import frf_pkg::*; #(
  parameter int MAX_FAULTS = DEF_MAX_FAULTS,
  parameter int SIG_BITS   = DEF_SIG_BITS
) (
  input  logic             in_valid_i,
  input  logic [1:0]       req_type_i,
  input  logic [FID_W-1:0] fault_id_i,
  input  logic [SIG_W-1:0] signature_i,
  input  logic [SZ_W-1:0]  fault_count_i,
  input  logic             q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output item_t            item_o
);

  localparam logic [SIG_W-1:0] SigMask =
    (SIG_BITS >= SIG_W) ? {SIG_W{1'b1}} : SIG_W'((64'd1 << SIG_BITS) - 64'd1);

  logic [SZ_W-1:0] live;
  logic            bad_id;

  // clamp the fault count to the map depth
  assign live   = (32'(fault_count_i) < 32'(MAX_FAULTS)) ? fault_count_i : SZ_W'(MAX_FAULTS);
  assign bad_id = 32'(fault_id_i) >= 32'(live);

  always_comb begin
    item_o.fid  = fault_id_i;
    item_o.key  = signature_i & SigMask;
    item_o.live = live;
    case (req_e'(req_type_i))
      REQ_BEGIN:  item_o.kind = K_BEGIN;
      REQ_VEND:   item_o.kind = K_VEND;
      REQ_REPORT: item_o.kind = bad_id ? K_BAD : K_REPORT;
      REQ_QUERY:  item_o.kind = bad_id ? K_BAD : K_QUERY;
      default:    item_o.kind = K_BAD;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

[src/frf_queue.sv]
`timescale 1ns / 1ps
module frf_queue import frf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output logic  full_o,
  output item_t head_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  item_t           mem_q [QDEPTH];
  logic [PW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CW'(QDEPTH);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (32'(wp_q) == QDEPTH - 1) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (32'(rp_q) == QDEPTH - 1) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule

[src/frf_back.sv]
`timescale 1ns / 1ps
module frf_back import frf_pkg::*; #(
  parameter int MAX_FAULTS = DEF_MAX_FAULTS,
  parameter int MAX_GROUPS = DEF_MAX_GROUPS,
  parameter int SIG_BITS   = DEF_SIG_BITS,
  parameter int DICT_DEPTH = DEF_DICT_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             drop_i,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [1:0]       status_o,
  output logic [GID_W-1:0] group_id_o,
  output logic [SZ_W-1:0]  group_members_o,
  output logic             skip_fault_o
);

  localparam int FA_W = $clog2(MAX_FAULTS);
  localparam int GA_W = $clog2(MAX_GROUPS);
  localparam int NG_W = $clog2(MAX_GROUPS + 1);
  localparam int DA_W = $clog2(DICT_DEPTH);
  localparam int DC_W = $clog2(DICT_DEPTH + 1);
  localparam int KW   = (SIG_BITS < SIG_W) ? SIG_BITS : SIG_W;
  localparam int SW_N = (MAX_FAULTS > DICT_DEPTH) ? MAX_FAULTS : DICT_DEPTH;
  localparam int SC_W = $clog2(SW_N);
  localparam int DE_W = EPOCH_W + KW + 2 * GA_W;
  localparam int HV_W = GA_W + KW;

  typedef enum logic [8:0] {
    S_SWEEP = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MAP   = 9'b000000100,
    S_PROBE = 9'b000001000,
    S_DEC   = 9'b000010000,
    S_INC   = 9'b000100000,
    S_QRES  = 9'b001000000,
    S_RES   = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_e;

  function automatic logic [DA_W-1:0] hash_f(input logic [HV_W-1:0] v);
    logic [DA_W-1:0] h;
    logic [DA_W:0]   hx;
    h = '0;
    for (int i = 0; i < HV_W; i++) h[i % DA_W] = h[i % DA_W] ^ v[i];
    hx = {1'b0, h};
    if (hx >= (DA_W + 1)'(DICT_DEPTH)) hx = hx - (DA_W + 1)'(DICT_DEPTH);
    return hx[DA_W-1:0];
  endfunction

  // storage
  logic [GA_W-1:0] map_mem  [MAX_FAULTS];
  logic [SZ_W-1:0] sz_mem   [MAX_GROUPS];
  logic [DE_W-1:0] dict_mem [DICT_DEPTH];

  logic [GA_W-1:0] map_rd_q;
  logic [SZ_W-1:0] sz_rd_q;
  logic [DE_W-1:0] dict_rd_q;

  logic            map_we, map_re, sz_we, sz_re, dict_we, dict_re;
  logic [FA_W-1:0] map_wa, map_ra;
  logic [GA_W-1:0] map_wd, sz_wa, sz_ra;
  logic [SZ_W-1:0] sz_wd;
  logic [DA_W-1:0] dict_wa, dict_ra;
  logic [DE_W-1:0] dict_wd;

  // control
  state_e              state_q, state_d;
  logic [NG_W-1:0]     nfg_q, nfg_d;
  logic [DC_W-1:0]     used_q, used_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [SC_W-1:0]     sc_q, sc_d;
  logic                sweep_map_q, sweep_map_d;
  logic                go_sweep_q, go_sweep_d;
  logic                out_valid_q, out_valid_d;

  // payload
  item_t               cur_q, cur_d;
  logic [GA_W-1:0]     og_q, og_d, g_q, g_d;
  logic                new_q, new_d;
  logic [DA_W-1:0]     pidx_q, pidx_d;
  logic [DC_W-1:0]     pcnt_q, pcnt_d;
  logic [SZ_W-1:0]     sz0_q, sz0_d;
  status_e             r_status_q, r_status_d;
  logic [GA_W-1:0]     r_g_q, r_g_d;
  logic [SZ_W-1:0]     r_sz_q, r_sz_d;
  logic                r_skip_q, r_skip_d;
  logic [1:0]          o_status_q, o_status_d;
  logic [GID_W-1:0]    o_gid_q, o_gid_d;
  logic [SZ_W-1:0]     o_sz_q, o_sz_d;
  logic                o_skip_q, o_skip_d;

  logic                res_ready, res_load;
  logic [FA_W-1:0]     head_fidx, cur_fidx;
  logic [EPOCH_W-1:0]  e_tag;
  logic [KW-1:0]       e_key;
  logic [GA_W-1:0]     e_og, e_val;
  logic                e_live, e_hit;
  logic [DA_W:0]       pidx_inc;
  logic [SZ_W-1:0]     sz_dec, sz_inc;

  assign res_ready = !out_valid_q || out_ready_i;
  assign head_fidx = FA_W'(q_item_i.fid);
  assign cur_fidx  = FA_W'(cur_q.fid);

  assign e_tag  = dict_rd_q[DE_W-1 -: EPOCH_W];
  assign e_key  = dict_rd_q[KW+2*GA_W-1 -: KW];
  assign e_og   = dict_rd_q[2*GA_W-1 -: GA_W];
  assign e_val  = dict_rd_q[GA_W-1:0];
  assign e_live = e_tag == epoch_q;
  assign e_hit  = e_live && (e_key == cur_q.key[KW-1:0]) && (e_og == og_q);

  assign pidx_inc = {1'b0, pidx_q} + 1'b1;
  assign sz_dec   = (sz_rd_q != '0) ? sz_rd_q - 1'b1 : sz_rd_q;
  assign sz_inc   = new_q ? SZ_W'(1) : ((sz_rd_q < SZ_SAT) ? sz_rd_q + 1'b1 : sz_rd_q);

  always_comb begin
    state_d     = state_q;
    nfg_d       = nfg_q;
    used_d      = used_q;
    epoch_d     = epoch_q;
    sc_d        = sc_q;
    sweep_map_d = sweep_map_q;
    go_sweep_d  = go_sweep_q;
    cur_d       = cur_q;
    og_d        = og_q;
    g_d         = g_q;
    new_d       = new_q;
    pidx_d      = pidx_q;
    pcnt_d      = pcnt_q;
    sz0_d       = sz0_q;
    r_status_d  = r_status_q;
    r_g_d       = r_g_q;
    r_sz_d      = r_sz_q;
    r_skip_d    = r_skip_q;
    o_status_d  = o_status_q;
    o_gid_d     = o_gid_q;
    o_sz_d      = o_sz_q;
    o_skip_d    = o_skip_q;
    res_load    = 1'b0;
    q_pop_o     = 1'b0;

    map_we = 1'b0; map_wa = cur_fidx; map_wd = g_q;
    map_re = 1'b0; map_ra = head_fidx;
    sz_we  = 1'b0; sz_wa  = og_q; sz_wd = sz_dec;
    sz_re  = 1'b0; sz_ra  = og_q;
    dict_we = 1'b0; dict_wa = pidx_q;
    dict_wd = {epoch_q, cur_q.key[KW-1:0], og_q, GA_W'(nfg_q)};
    dict_re = 1'b0; dict_ra = pidx_q;

    case (state_q)
      S_SWEEP: begin
        // clear the dictionary tags (on a full sweep also the fault map and group 0 size), one entry a cycle
        if (sweep_map_q && (32'(sc_q) < MAX_FAULTS)) begin
          map_we = 1'b1;
          map_wa = sc_q[FA_W-1:0];
          map_wd = '0;
        end
        if (32'(sc_q) < DICT_DEPTH) begin
          dict_we = 1'b1;
          dict_wa = sc_q[DA_W-1:0];
          dict_wd = '0;
        end
        if (sweep_map_q && (sc_q == '0)) begin
          sz_we = 1'b1;
          sz_wa = '0;
          sz_wd = sz0_q;
        end
        sc_d = sc_q + 1'b1;
        if (sc_q == SC_W'(SW_N - 1)) begin
          sc_d    = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o    = 1'b1;
          cur_d      = q_item_i;
          r_status_d = ST_OK;
          r_g_d      = '0;
          r_sz_d     = '0;
          r_skip_d   = 1'b0;
          go_sweep_d = 1'b0;
          case (q_item_i.kind)
            K_BEGIN: begin
              r_sz_d      = q_item_i.live;
              r_skip_d    = drop_i && (q_item_i.live <= SZ_W'(1));
              sz0_d       = q_item_i.live;
              go_sweep_d  = 1'b1;
              sweep_map_d = 1'b1;
              nfg_d       = NG_W'(1);
              used_d      = '0;
              epoch_d     = EPOCH_W'(1);
              state_d     = S_RES;
            end
            K_VEND: begin
              used_d = '0;
              if (epoch_q == '1) begin
                // tags would wrap: wipe them before reuse
                go_sweep_d  = 1'b1;
                sweep_map_d = 1'b0;
                epoch_d     = EPOCH_W'(1);
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
              state_d = S_RES;
            end
            K_REPORT, K_QUERY: begin
              map_re  = 1'b1;
              map_ra  = head_fidx;
              state_d = S_MAP;
            end
            default: begin
              r_status_d = ST_BAD_ID;
              state_d    = S_RES;
            end
          endcase
        end
      end
      S_MAP: begin
        og_d = map_rd_q;
        if (cur_q.kind == K_QUERY) begin
          sz_re   = 1'b1;
          sz_ra   = map_rd_q;
          state_d = S_QRES;
        end else begin
          dict_re = 1'b1;
          dict_ra = hash_f({map_rd_q, cur_q.key[KW-1:0]});
          pidx_d  = dict_ra;
          pcnt_d  = DC_W'(1);
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (e_hit) begin
          g_d     = e_val;
          new_d   = 1'b0;
          map_we  = 1'b1;
          map_wd  = e_val;
          sz_re   = 1'b1;
          state_d = S_DEC;
        end else if (e_live && (pcnt_q < DC_W'(DICT_DEPTH))) begin
          // advance linear probe
          pidx_d  = (pidx_inc == (DA_W + 1)'(DICT_DEPTH)) ? '0 : pidx_inc[DA_W-1:0];
          dict_re = 1'b1;
          dict_ra = pidx_d;
          pcnt_d  = pcnt_q + 1'b1;
        end else if (nfg_q >= NG_W'(MAX_GROUPS)) begin
          r_status_d = ST_GROUPS_OUT;
          r_g_d      = '0;
          r_sz_d     = '0;
          r_skip_d   = 1'b0;
          state_d    = S_RES;
        end else if (used_q >= DC_W'(DICT_DEPTH)) begin
          r_status_d = ST_DICT_FULL;
          r_g_d      = '0;
          r_sz_d     = '0;
          r_skip_d   = 1'b0;
          state_d    = S_RES;
        end else begin
          dict_we = 1'b1;
          g_d     = GA_W'(nfg_q);
          new_d   = 1'b1;
          nfg_d   = nfg_q + 1'b1;
          used_d  = used_q + 1'b1;
          map_we  = 1'b1;
          map_wd  = GA_W'(nfg_q);
          sz_re   = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        sz_we = 1'b1;
        sz_wa = og_q;
        sz_wd = sz_dec;
        if (!new_q) begin
          sz_re = 1'b1;
          sz_ra = g_q;
        end
        state_d = S_INC;
      end
      S_INC: begin
        if (res_ready) begin
          sz_we      = 1'b1;
          sz_wa      = g_q;
          sz_wd      = sz_inc;
          res_load   = 1'b1;
          o_status_d = ST_OK;
          o_gid_d    = GID_W'(g_q);
          o_sz_d     = sz_inc;
          o_skip_d   = drop_i && (sz_inc <= SZ_W'(1));
          state_d    = S_IDLE;
        end
      end
      S_QRES: begin
        if (res_ready) begin
          res_load   = 1'b1;
          o_status_d = ST_OK;
          o_gid_d    = GID_W'(og_q);
          o_sz_d     = sz_rd_q;
          o_skip_d   = drop_i && (sz_rd_q <= SZ_W'(1));
          state_d    = S_IDLE;
        end
      end
      S_RES: begin
        if (res_ready) begin
          res_load   = 1'b1;
          o_status_d = r_status_q;
          o_gid_d    = GID_W'(r_g_q);
          o_sz_d     = r_sz_q;
          o_skip_d   = r_skip_q;
          sc_d       = '0;
          state_d    = go_sweep_q ? S_SWEEP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (res_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      nfg_q       <= NG_W'(1);
      used_q      <= '0;
      epoch_q     <= EPOCH_W'(1);
      sc_q        <= '0;
      sweep_map_q <= 1'b1;
      go_sweep_q  <= 1'b0;
      out_valid_q <= 1'b0;
      sz0_q       <= '0;
    end else begin
      state_q     <= state_d;
      nfg_q       <= nfg_d;
      used_q      <= used_d;
      epoch_q     <= epoch_d;
      sc_q        <= sc_d;
      sweep_map_q <= sweep_map_d;
      go_sweep_q  <= go_sweep_d;
      out_valid_q <= out_valid_d;
      sz0_q       <= sz0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    og_q       <= og_d;
    g_q        <= g_d;
    new_q      <= new_d;
    pidx_q     <= pidx_d;
    pcnt_q     <= pcnt_d;
    r_status_q <= r_status_d;
    r_g_q      <= r_g_d;
    r_sz_q     <= r_sz_d;
    r_skip_q   <= r_skip_d;
    o_status_q <= o_status_d;
    o_gid_q    <= o_gid_d;
    o_sz_q     <= o_sz_d;
    o_skip_q   <= o_skip_d;
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_rd_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sz_we) sz_mem[sz_wa] <= sz_wd;
    if (sz_re) sz_rd_q <= sz_mem[sz_ra];
  end

  always_ff @(posedge clk_i) begin
    if (dict_we) dict_mem[dict_wa] <= dict_wd;
    if (dict_re) dict_rd_q <= dict_mem[dict_ra];
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = o_status_q;
  assign group_id_o      = o_gid_q;
  assign group_members_o = o_sz_q;
  assign skip_fault_o    = o_skip_q;

endmodule
